/* rtl/core/glf_pkg.sv */
// glf_pkg: shared types, character codes and state encoding for the line fold core
// no dependencies; imported by glf_out_reg and greedy_line_fold_core
`timescale 1ns / 1ps
`default_nettype none

package glf_pkg;

    localparam int MAX_COLUMNS_DEFAULT = 32;
    localparam int FOLD_W              = 6;
    localparam logic [FOLD_W-1:0] FOLD_COLUMN_RESET = 6'd20;

    localparam logic [7:0] CH_BLANK   = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

    typedef struct packed {
        logic [7:0] in_char;
        logic       flush;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_NL
    } glf_state_t;

    function automatic logic is_blank(input logic [7:0] ch);
        return (ch == CH_BLANK) || (ch == CH_TAB);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/greedy_line_fold_core.sv */
// greedy_line_fold_core: greedy word wrap of a byte stream around a segment memory
// depends on glf_pkg and glf_out_reg
`timescale 1ns / 1ps
`default_nettype none

// channel   | signals                          | direction | moves
// ----------+----------------------------------+-----------+-------------------------
// char      | char_valid char_stall char_word  | in        | one text byte or a flush
// fold      | fold_valid fold_stall fold_word  | out       | one folded output byte
// cfg       | cfg_we cfg_wdata                 | in        | fold column write
//
// bytes that only append to the segment keep the core idle, so they can stream
// in every cycle. each emitted byte takes a memory read, then a load of the
// output register; an inserted newline takes the load alone. a fold first scans
// the segment memory backward for a blank, reading then checking up to limit
// entries. output stalls hold the emit states; no input word is taken
// until all bytes of the current word have entered the output register.
// reset clears the fill count, head pointer and state; the memory needs no
// clearing since only entries below the fill count are ever read.

module greedy_line_fold_core
    import glf_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              char_valid,
    output logic                   char_stall,
    input  wire in_word_t          char_word,
    output logic                   fold_valid,
    input  wire logic              fold_stall,
    output out_word_t              fold_word,
    input  wire logic              cfg_we,
    input  wire logic [FOLD_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(MAX_COLUMNS);
    localparam int CW = $clog2(MAX_COLUMNS + 1);

    // circular address: base plus offset, one wrap at most
    function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                                input logic [CW-1:0] offs);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(offs);
        if (s >= (CW+1)'(MAX_COLUMNS))
        begin
            s = s - (CW+1)'(MAX_COLUMNS);
        end
        return s[AW-1:0];
    endfunction

    glf_state_t      state_reg, state_next;
    logic [FOLD_W-1:0] fold_column_reg;
    logic [CW-1:0]   count_reg, count_next;   // bytes buffered
    logic [AW-1:0]   head_reg, head_next;     // memory slot of segment byte 0
    logic [AW-1:0]   idx_reg, idx_next;       // blank scan position
    logic [AW-1:0]   k_reg, k_next;           // emit position
    logic [CW-1:0]   len_reg, len_next;       // bytes to emit from the segment
    logic [CW-1:0]   cut_reg, cut_next;       // bytes dropped after a fold
    logic            nl_reg, nl_next;         // newline follows the prefix
    logic            fold_reg, fold_next;     // word ends with cut and append
    logic [7:0]      ch_reg, ch_next;         // byte appended after a fold

    // segment memory, one write and one registered read per cycle
    logic [7:0]      seg_mem [MAX_COLUMNS];
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [7:0]      mem_rdata_reg;

    logic            out_load;
    out_word_t       out_load_word;
    logic            out_free;

    logic [CW-1:0]   limit;
    logic            k_last;

    // effective column limit, clamped to 1..MAX_COLUMNS
    always_comb
    begin
        if (fold_column_reg == '0)
        begin
            limit = CW'(1);
        end
        else if (fold_column_reg > FOLD_W'(MAX_COLUMNS))
        begin
            limit = CW'(MAX_COLUMNS);
        end
        else
        begin
            limit = CW'(fold_column_reg);
        end
    end

    assign k_last     = (CW'(k_reg) + CW'(1)) == len_reg;
    assign char_stall = (state_reg != S_IDLE);

    // sequencer: every memory write happens in a state that issues no read, and
    // a read is issued in a later cycle than the write it depends on
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        idx_next      = idx_reg;
        k_next        = k_reg;
        len_next      = len_reg;
        cut_next      = cut_reg;
        nl_next       = nl_reg;
        fold_next     = fold_reg;
        ch_next       = ch_reg;
        mem_we        = 1'b0;
        mem_waddr     = wrap_addr(head_reg, count_reg);
        mem_wdata     = char_word.in_char;
        mem_re        = 1'b0;
        mem_raddr     = wrap_addr(head_reg, CW'(k_reg));
        out_load      = 1'b0;
        out_load_word = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (char_valid)
                begin
                    k_next = '0;
                    if (char_word.flush)
                    begin
                        // flush: emit the segment without a newline
                        if (count_reg != '0)
                        begin
                            len_next   = count_reg;
                            nl_next    = 1'b0;
                            fold_next  = 1'b0;
                            state_next = S_EMIT_RD;
                        end
                    end
                    else if (char_word.in_char == CH_NEWLINE)
                    begin
                        len_next   = count_reg;
                        nl_next    = 1'b1;
                        fold_next  = 1'b0;
                        state_next = (count_reg == '0) ? S_EMIT_NL : S_EMIT_RD;
                    end
                    else if (count_reg < limit)
                    begin
                        // plain append, no output
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else if ((count_reg == limit) && is_blank(char_word.in_char))
                    begin
                        // blank at a full segment becomes the newline itself
                        len_next   = count_reg;
                        nl_next    = 1'b1;
                        fold_next  = 1'b0;
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        ch_next    = char_word.in_char;
                        idx_next   = AW'(limit - CW'(1));
                        nl_next    = 1'b1;
                        fold_next  = 1'b1;
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = wrap_addr(head_reg, CW'(idx_reg));
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                k_next = '0;
                if (is_blank(mem_rdata_reg))
                begin
                    // last blank below the limit becomes the newline
                    len_next   = CW'(idx_reg);
                    cut_next   = CW'(idx_reg) + CW'(1);
                    state_next = (idx_reg == '0) ? S_EMIT_NL : S_EMIT_RD;
                end
                else if (idx_reg == '0)
                begin
                    // no blank: hard break at the limit
                    len_next   = limit;
                    cut_next   = limit;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_EMIT_RD:
            begin
                if (out_free)
                begin
                    mem_re     = 1'b1;
                    state_next = S_EMIT_LD;
                end
            end

            S_EMIT_LD:
            begin
                // output register is known empty here
                out_load               = 1'b1;
                out_load_word.out_char = mem_rdata_reg;
                out_load_word.last     = !nl_reg && k_last;
                if (k_last)
                begin
                    if (nl_reg)
                    begin
                        state_next = S_EMIT_NL;
                    end
                    else
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    k_next     = k_reg + AW'(1);
                    state_next = S_EMIT_RD;
                end
            end

            S_EMIT_NL:
            begin
                if (out_free)
                begin
                    out_load               = 1'b1;
                    out_load_word.out_char = CH_NEWLINE;
                    out_load_word.last     = 1'b1;
                    if (fold_reg)
                    begin
                        // old head plus old count is the slot after the kept tail
                        mem_we     = 1'b1;
                        mem_wdata  = ch_reg;
                        head_next  = wrap_addr(head_reg, cut_reg);
                        count_next = count_reg - cut_reg + CW'(1);
                    end
                    else
                    begin
                        count_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            head_reg        <= '0;
            fold_column_reg <= FOLD_COLUMN_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            if (cfg_we)
            begin
                fold_column_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        k_reg    <= k_next;
        len_reg  <= len_next;
        cut_reg  <= cut_next;
        nl_reg   <= nl_next;
        fold_reg <= fold_next;
        ch_reg   <= ch_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seg_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_rdata_reg <= seg_mem[mem_raddr];
        end
    end

    glf_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_word (out_load_word),
        .free      (out_free),
        .valid     (fold_valid),
        .stall     (fold_stall),
        .word      (fold_word)
    );

    // fill count never passes the memory depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_COLUMNS))
        else $error("segment count above depth");

    // the output register is empty whenever a byte is loaded from memory
    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_LD) |-> !fold_valid)
        else $error("output register busy on memory load");

    // a fold only starts on a segment at or above the limit
    a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_RD || state_reg == S_SCAN_CHK) |-> (count_reg >= limit))
        else $error("blank scan on a short segment");

    // the closing newline ends the word
    a_nl_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_NL && out_free) |=> (state_reg == S_IDLE && fold_word.last))
        else $error("newline did not close the word");

endmodule

`default_nettype wire

/* rtl/core/glf_out_reg.sv */
// glf_out_reg: output word register between the fold sequencer and the output channel
// depends on glf_pkg for the output word type
`timescale 1ns / 1ps
`default_nettype none

module glf_out_reg
    import glf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  wire out_word_t load_word,
    output logic           free,
    output logic           valid,
    input  wire logic      stall,
    output out_word_t      word
);

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    // free when empty or being taken at this edge
    assign free = !valid_reg || !stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule

`default_nettype wire

/* test/greedy_line_fold_core_test.sv */
// greedy_line_fold_core_test: self-checking bench for the greedy line fold core
// drives text bytes and flushes with random gaps and output stalls, and checks
// every folded byte against a behavioral fold model; depends on glf_pkg and the core
`timescale 1ns / 1ps

module greedy_line_fold_core_test;
    import glf_pkg::*;

    localparam int  SEG_DEPTH     = 32;
    // covers a fold that scans every segment entry, then emits up to 33 bytes
    localparam int  SETTLE_CYCLES = 160;
    localparam int  MAX_REPORTS   = 40;
    localparam int  WORDS_PER_SET = 54;
    localparam longint TIMEOUT_NS = 64'd40_000_000;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 char_valid = 1'b0;
    logic                 char_stall;
    in_word_t             char_word  = '0;
    logic                 fold_valid;
    logic                 fold_stall = 1'b0;
    out_word_t            fold_word;
    logic                 cfg_we     = 1'b0;
    logic [FOLD_W-1:0]    cfg_wdata  = '0;

    // text words waiting for the driver, and folded bytes waiting for the block
    in_word_t             pending_words[$];
    out_word_t            folded_due[$];

    // fold model state
    logic [7:0]           seg_mem [0:SEG_DEPTH-1];
    int                   seg_fill = 0;
    logic [FOLD_W-1:0]    fold_col = FOLD_COLUMN_RESET;

    int                   words_queued  = 0;
    int                   words_taken   = 0;
    int                   bytes_checked = 0;
    int                   newlines_seen = 0;
    int                   col_writes    = 0;
    int                   errors        = 0;
    bit                   word_taken    = 1'b0;

    greedy_line_fold_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word),
        .fold_valid (fold_valid),
        .fold_stall (fold_stall),
        .fold_word  (fold_word),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    function automatic bit is_space(input logic [7:0] c);
        return (c == CH_BLANK) || (c == CH_TAB);
    endfunction

    // gap length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // printable most of the time, otherwise any byte that is neither blank, tab nor newline
    function automatic logic [7:0] pick_visible();
        logic [7:0] c;
        if ($urandom_range(99) < 85)
            return 8'($urandom_range(33, 126));
        do
            c = 8'($urandom_range(255));
        while (is_space(c) || c == CH_NEWLINE);
        return c;
    endfunction

    // fold model: one accepted text word in, the bytes it releases appended to folded_due
    task automatic fold_next(input in_word_t w);
        out_word_t  burst[$];
        int         lim;
        int         cut;
        int         i;
        int         k;
        bit         found;
        lim = (fold_col == 0) ? 1 : ((fold_col > SEG_DEPTH) ? SEG_DEPTH : int'(fold_col));
        if (w.flush)
        begin
            // flush releases the segment alone, nothing at all when it is empty
            for (k = 0; k < seg_fill; k++)
                burst.push_back(out_word_t'{out_char: seg_mem[k], last: 1'b0});
            seg_fill = 0;
        end
        else if (w.in_char == CH_NEWLINE)
        begin
            for (k = 0; k < seg_fill; k++)
                burst.push_back(out_word_t'{out_char: seg_mem[k], last: 1'b0});
            burst.push_back(out_word_t'{out_char: CH_NEWLINE, last: 1'b0});
            seg_fill = 0;
        end
        else if (seg_fill < lim)
        begin
            seg_mem[seg_fill] = w.in_char;
            seg_fill++;
        end
        else if (seg_fill == lim && is_space(w.in_char))
        begin
            // a blank on a full segment turns into the line break itself
            for (k = 0; k < seg_fill; k++)
                burst.push_back(out_word_t'{out_char: seg_mem[k], last: 1'b0});
            burst.push_back(out_word_t'{out_char: CH_NEWLINE, last: 1'b0});
            seg_fill = 0;
        end
        else
        begin
            // look for the last blank below the limit; it becomes the newline
            i = lim;
            found = 1'b0;
            while (i > 0 && !found)
            begin
                i--;
                if (is_space(seg_mem[i]))
                    found = 1'b1;
            end
            cut = found ? i : lim;
            for (k = 0; k < cut; k++)
                burst.push_back(out_word_t'{out_char: seg_mem[k], last: 1'b0});
            burst.push_back(out_word_t'{out_char: CH_NEWLINE, last: 1'b0});
            if (found)
                cut = i + 1;
            if (cut > seg_fill)
                cut = seg_fill;
            for (k = 0; k < seg_fill - cut; k++)
                seg_mem[k] = seg_mem[k + cut];
            seg_fill -= cut;
            if (seg_fill < SEG_DEPTH)
            begin
                seg_mem[seg_fill] = w.in_char;
                seg_fill++;
            end
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[k])
            folded_due.push_back(burst[k]);
    endtask

    // input driver: new word only once the current one is taken, then an optional gap
    int text_gap  = 0;
    int text_calm = 0;

    always @(negedge clk)
    begin
        if (rst_n && (!char_valid || word_taken))
        begin
            word_taken = 1'b0;
            if (text_gap > 0)
            begin
                text_gap--;
                char_valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                char_word  <= pending_words.pop_front();
                char_valid <= 1'b1;
                // calm stretches keep the input streaming back to back
                if (text_calm > 0)
                begin
                    text_calm--;
                    text_gap = 0;
                end
                else
                begin
                    text_gap = pick_gap();
                    if ($urandom_range(29) == 0)
                        text_calm = $urandom_range(15, 60);
                end
            end
            else
            begin
                char_valid <= 1'b0;
            end
        end
    end

    // output stall: random runs of stall with unstalled cycles between them
    int stall_left = 0;
    int stall_calm = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                fold_stall <= 1'b1;
            end
            else
            begin
                fold_stall <= 1'b0;
                if (stall_calm > 0)
                    stall_calm--;
                else
                begin
                    stall_left = pick_gap();
                    if ($urandom_range(29) == 0)
                        stall_calm = $urandom_range(20, 80);
                end
            end
        end
    end

    // monitor: check the folded word first, then run the model on the accepted text word
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n)
        begin
            if (fold_valid && !fold_stall)
            begin
                if (folded_due.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: folded word with none expected, got char %h last %b",
                                 $time, fold_word.out_char, fold_word.last);
                end
                else
                begin
                    want = folded_due.pop_front();
                    bytes_checked++;
                    if (want.out_char == CH_NEWLINE)
                        newlines_seen++;
                    if (fold_word.out_char !== want.out_char)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: out_char expected %h, got %h",
                                     $time, want.out_char, fold_word.out_char);
                    end
                    if (fold_word.last !== want.last)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: last expected %b, got %b",
                                     $time, want.last, fold_word.last);
                    end
                end
            end
            if (char_valid && !char_stall)
            begin
                fold_next(char_word);
                words_taken++;
                word_taken = 1'b1;
            end
        end
    end

    task automatic queue_char(input logic [7:0] c);
        pending_words.push_back(in_word_t'{in_char: c, flush: 1'b0});
        words_queued++;
    endtask

    // the char field of a flush is ignored, so fill it with anything
    task automatic queue_flush();
        pending_words.push_back(in_word_t'{in_char: 8'($urandom_range(255)), flush: 1'b1});
        words_queued++;
    endtask

    task automatic queue_string(input string s);
        for (int k = 0; k < s.len(); k++)
            queue_char(s[k]);
    endtask

    // block is idle: all text taken, all folded bytes seen, and any scan has run out
    task automatic wait_quiet();
        while (words_taken != words_queued || folded_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_fold_column(input logic [FOLD_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        fold_col   = v;
        col_writes++;
    endtask

    // random text: mostly words and separators, some stray bytes, flushes and blank runs
    task automatic make_text(input int n);
        int made;
        int len;
        int r;
        made = 0;
        while (made < n)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                // now and then a long word of 9 to 40 bytes, which may be longer than the line
                len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    queue_char(pick_visible());
                made += len + 1;
                r = $urandom_range(99);
                if (r < 55)
                    queue_char(CH_BLANK);
                else if (r < 70)
                    queue_char(CH_TAB);
                else if (r < 80)
                begin
                    queue_char(CH_BLANK);
                    queue_char(CH_TAB);
                    made++;
                end
                else if (r < 93)
                    queue_char(CH_NEWLINE);
                else
                    queue_flush();
            end
            else if (r < 88)
            begin
                queue_char(8'($urandom_range(255)));
                made++;
            end
            else if (r < 94)
            begin
                queue_flush();
                made++;
            end
            else
            begin
                len = $urandom_range(2, 6);
                for (int k = 0; k < len; k++)
                    queue_char(($urandom_range(1) == 0) ? CH_BLANK : CH_TAB);
                made += len;
            end
        end
    endtask

    initial
    begin
        logic [FOLD_W-1:0] settings [7];

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at a short line of four columns
        set_fold_column(6'd4);
        queue_flush();                      // flush of an empty segment releases nothing
        queue_string("ab cd");              // fold at the blank: "ab" then newline
        queue_char(CH_NEWLINE);             // newline releases "cd" and itself
        queue_string("wxyz");
        queue_char(CH_TAB);                 // tab on a full segment becomes the break
        queue_string(" pqrs");              // blank only at the start gives an empty line
        queue_char("t");                    // no blank at all: full segment plus newline
        queue_char(8'h00);
        queue_char(8'hff);
        queue_flush();
        wait_quiet();

        // limit lowered while a long segment is buffered
        set_fold_column(6'd20);
        queue_string("ab cdefgh");
        wait_quiet();
        set_fold_column(6'd3);
        queue_string("xy");
        queue_flush();
        wait_quiet();

        // random text under a range of columns, out-of-range values among them
        settings[0] = 6'd0;
        settings[1] = 6'd63;
        settings[2] = 6'd1;
        settings[3] = 6'd32;
        settings[4] = 6'($urandom_range(1, 32));
        settings[5] = 6'($urandom_range(33, 63));
        settings[6] = 6'($urandom_range(2, 12));
        foreach (settings[s])
        begin
            set_fold_column(settings[s]);
            make_text(WORDS_PER_SET);
            wait_quiet();
        end

        if (folded_due.size() != 0)
        begin
            errors++;
            $display("%0t: %0d folded words never arrived, next expected %h",
                     $time, folded_due.size(), folded_due[0].out_char);
        end

        $display("text words in: %0d, folded bytes checked: %0d (%0d newlines)",
                 words_taken, bytes_checked, newlines_seen);
        $display("fold column written %0d times, errors: %0d", col_writes, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
